[hw/rtl/mco_pkg.sv]
// Matrix-chain order package: payload structs, token kinds, datapath command struct.
// No dependencies.
`default_nettype none
package mco_pkg;
  localparam int IDX_BITS = 4;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_COST  = 2'd0;
  localparam kind_t KIND_OPEN  = 2'd1;
  localparam kind_t KIND_CLOSE = 2'd2;
  localparam kind_t KIND_MAT   = 2'd3;

  typedef struct packed {
    logic [10:0] dimension;
    logic        last_dimension;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [39:0] token_value;
    logic        last_token;
  } out_item_t;

  typedef struct packed {
    logic clr_best;   // start a new interval minimum
    logic calc;       // compute candidate from registered operands
    logic commit;     // write best to tables
  } dp_cmd_t;
endpackage
`default_nettype wire

[hw/rtl/mco_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/mco_datapath.sv]
// Matrix-chain datapath: dimension store, cost/split tables, candidate cost pipe.
// Depends on mco_pkg and mco_ram.
`default_nettype none
module mco_datapath #(
  parameter int DIM_BITS  = 11,
  parameter int COST_BITS = 40
) (
  input  wire logic                 clk,
  input  wire logic                 dim_we,
  input  wire logic [4:0]           dim_waddr,
  input  wire logic [DIM_BITS-1:0]  dim_wdata,
  input  wire logic [4:0]           dim_raddr_a,
  input  wire logic [3:0]           ci,
  input  wire logic [3:0]           ct,
  input  wire logic [3:0]           cj,
  input  wire mco_pkg::dp_cmd_t     cmd,
  input  wire logic                 diag_we,
  input  wire logic [7:0]           sp_raddr,
  output logic [3:0]                sp_rdata,
  output logic [COST_BITS-1:0]      cost_q
);
  // Dimension store in flops (17 entries, fixed reads by i,t+1,j+1 -> small)
  logic [DIM_BITS-1:0] dims_r [17];
  logic [DIM_BITS-1:0] di_r, dt_r, dj_r;
  logic [DIM_BITS-1:0] dj_d_r;
  logic [COST_BITS-1:0] c_a, c_b, best_r, sum_r, cand;
  logic [2*DIM_BITS-1:0] p1, prod1_r;
  logic [3*DIM_BITS-1:0] p2;
  logic [3:0] bs_r;
  logic [3:0] ct_d1_r, ct_d2_r;
  logic [7:0] cost_waddr;
  logic [COST_BITS-1:0] cost_wdata;
  logic cost_we;
  logic [COST_BITS-1:0] cost_rd_a, cost_rd_b;

  always_ff @(posedge clk) begin
    if (dim_we) begin
      dims_r[dim_waddr] <= dim_wdata;
    end
  end

  // Two cost reads per candidate: two RAM copies, same writes.
  assign cost_we    = cmd.commit || diag_we;
  assign cost_waddr = {ci, cj};
  assign cost_wdata = diag_we ? '0 : best_r;

  mco_ram #(.WIDTH(COST_BITS), .DEPTH(256)) u_cost_a (
    .clk, .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr({ci, ct}), .rdata(cost_rd_a));
  mco_ram #(.WIDTH(COST_BITS), .DEPTH(256)) u_cost_b (
    .clk, .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr({ct + 4'd1, cj}), .rdata(cost_rd_b));
  mco_ram #(.WIDTH(4), .DEPTH(256)) u_split (
    .clk, .we(cmd.commit), .waddr(cost_waddr), .wdata(bs_r),
    .raddr(sp_raddr), .rdata(sp_rdata));

  // Stage 1 (with RAM read): fetch dims. Stage 2: di*dt, sum costs.
  // Stage 3: *dj and add, compare.
  always_ff @(posedge clk) begin
    di_r    <= dims_r[dim_raddr_a];
    dt_r    <= dims_r[{1'b0, ct} + 5'd1];
    dj_r    <= dims_r[{1'b0, cj} + 5'd1];
    ct_d1_r <= ct;
    ct_d2_r <= ct_d1_r;
    prod1_r <= p1;
    sum_r   <= c_a + c_b;
  end
  assign c_a  = cost_rd_a;
  assign c_b  = cost_rd_b;
  assign p1   = di_r * dt_r;
  assign p2   = prod1_r * dj_d_r;
  assign cand = sum_r + COST_BITS'(p2);

  always_ff @(posedge clk) begin
    dj_d_r <= dj_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      if (cmd.clr_best || cand < best_r) begin
        best_r <= cand;
        bs_r   <= ct_d2_r;
      end
    end else if (diag_we) begin
      best_r <= '0;
    end
  end
  assign cost_q = best_r;
endmodule
`default_nettype wire

[hw/rtl/mco_ctrl.sv]
// Matrix-chain controller: load, DP sweep sequencing, traceback stack, token output.
// Depends on mco_pkg.
`default_nettype none
module mco_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mco_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mco_pkg::out_item_t     out_data,
  output logic                   dim_we,
  output logic [4:0]             dim_waddr,
  output logic [4:0]             dim_raddr_a,
  output logic [3:0]             ci,
  output logic [3:0]             ct,
  output logic [3:0]             cj,
  output mco_pkg::dp_cmd_t       cmd,
  output logic                   diag_we,
  output logic [7:0]             sp_raddr,
  input  wire logic [3:0]        sp_rdata,
  input  wire logic [39:0]       cost_q
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_DIAG  = 4'd1;
  localparam logic [3:0] S_ISSUE = 4'd2;
  localparam logic [3:0] S_DRAIN = 4'd3;
  localparam logic [3:0] S_COMMIT= 4'd4;
  localparam logic [3:0] S_COST  = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_SPLIT = 4'd7;
  localparam logic [3:0] S_SPW   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_WAIT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [3:0] n1_r, n1_nxt;      // n-1
  logic [3:0] len_r, len_nxt, i_r, i_nxt, t_r, t_nxt;
  logic [2:0] pipe_r, pipe_nxt;  // calc valid shift, 3 stages
  logic       first_r, first_nxt;
  logic [8:0] stk_r [32];
  logic [5:0] sp_r, sp_nxt;
  logic [8:0] item_r, item_nxt;
  logic       obuf_v_r, obuf_v_nxt;
  mco_pkg::out_item_t obuf_r, obuf_nxt;
  mco_pkg::out_item_t tok_r, tok_nxt;  // next token, loaded into obuf when free
  logic [3:0] ret_r, ret_nxt;    // state after emit
  logic       push_en;
  logic [8:0] push0, push1, push2;
  logic [3:0] j_w;

  assign j_w       = i_r + len_r;
  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = obuf_v_r;
  assign out_data  = obuf_r;
  assign dim_we    = (state_r == S_LOAD) && in_valid && (cnt_r < 5'd17);
  assign dim_waddr = cnt_r;
  assign dim_raddr_a = {1'b0, ci};
  assign ci = (state_r == S_DIAG) ? i_r : i_r;
  assign ct = t_r;
  assign cj = (state_r == S_DIAG) ? i_r : j_w;
  assign diag_we = (state_r == S_DIAG);
  assign cmd = '{clr_best: first_r, calc: pipe_r[1], commit: (state_r == S_COMMIT)};
  assign sp_raddr = item_r[7:0];
  assign push_en = (state_r == S_SPW);

  // single matrix: the root opens a bracket around one leaf
  always_comb begin
    push0 = 9'h100;
    push1 = {1'b0, sp_rdata + 4'd1, item_r[3:0]};
    push2 = {1'b0, item_r[7:4], sp_rdata};
    if (n1_r == 4'd0) begin
      push1 = {1'b0, 4'd0, 4'd0};
      push2 = {1'b0, 4'd0, 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_POP && sp_r == 6'd0) begin
      stk_r[0] <= {1'b0, 4'd0, n1_r};
    end
    if (push_en) begin
      stk_r[sp_r[4:0]]        <= push0;
      stk_r[sp_r[4:0] + 5'd1] <= push1;
      stk_r[sp_r[4:0] + 5'd2] <= push2;
    end
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; n1_nxt = n1_r; len_nxt = len_r;
    i_nxt = i_r; t_nxt = t_r; pipe_nxt = {pipe_r[1:0], 1'b0}; first_nxt = first_r;
    sp_nxt = sp_r; item_nxt = item_r; obuf_v_nxt = obuf_v_r; obuf_nxt = obuf_r;
    tok_nxt = tok_r; ret_nxt = ret_r;
    if (obuf_v_r && !out_stall) obuf_v_nxt = 1'b0;
    if (pipe_r[1]) first_nxt = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < 5'd17) cnt_nxt = cnt_r + 5'd1;
          if (in_data.last_dimension) begin
            cnt_nxt = '0;
            if (cnt_r == 5'd0) begin
              tok_nxt = '{mco_pkg::KIND_COST, 40'd0, 1'b1};
              state_nxt = S_WAIT; ret_nxt = S_LOAD;
            end else begin
              n1_nxt = (cnt_r < 5'd17) ? 4'(cnt_r - 5'd1) : 4'd15;
              i_nxt = '0; state_nxt = S_DIAG;
            end
          end
        end
      end
      S_DIAG: begin
        if (i_r == n1_r) begin
          len_nxt = 4'd1; i_nxt = '0; t_nxt = '0; first_nxt = 1'b1;
          state_nxt = (n1_r == 4'd0) ? S_COST : S_ISSUE;
        end else i_nxt = i_r + 4'd1;
      end
      S_ISSUE: begin
        pipe_nxt[0] = 1'b1;
        if (t_r == j_w - 4'd1) state_nxt = S_DRAIN;
        else t_nxt = t_r + 4'd1;
      end
      S_DRAIN: if (pipe_r == 3'b000) state_nxt = S_COMMIT;
      S_COMMIT: begin
        first_nxt = 1'b1;
        if ({1'b0, j_w} == {1'b0, n1_r}) begin
          if (len_r == n1_r) state_nxt = S_COST;
          else begin
            len_nxt = len_r + 4'd1; i_nxt = '0; t_nxt = '0; state_nxt = S_ISSUE;
          end
        end else begin
          i_nxt = i_r + 4'd1; t_nxt = i_r + 4'd1; state_nxt = S_ISSUE;
        end
      end
      S_COST: begin
        // cost_q holds the last committed best (whole chain) or 0 for one matrix
        tok_nxt = '{mco_pkg::KIND_COST, (n1_r == 4'd0) ? 40'd0 : cost_q, 1'b0};
        sp_nxt = '0; state_nxt = S_WAIT; ret_nxt = S_POP;
        item_nxt = {1'b0, 4'd0, n1_r};
      end
      S_POP: begin
        item_nxt = stk_r[sp_r[4:0] - 5'd1];
        if (sp_r == 6'd0) item_nxt = {1'b0, 4'd0, n1_r};
        else sp_nxt = sp_r - 6'd1;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (item_r[8]) begin
          tok_nxt = '{mco_pkg::KIND_CLOSE, 40'd0, sp_r == 6'd0};
          state_nxt = S_WAIT; ret_nxt = (sp_r == 6'd0) ? S_LOAD : S_POP;
        end else if (item_r[7:4] == item_r[3:0] &&
                     !(n1_r == 4'd0 && sp_r == 6'd0)) begin
          tok_nxt = '{mco_pkg::KIND_MAT, 40'(item_r[3:0]) + 40'd1, sp_r == 6'd0};
          state_nxt = S_WAIT; ret_nxt = (sp_r == 6'd0) ? S_LOAD : S_POP;
        end else state_nxt = S_SPW;
      end
      S_SPW: begin
        sp_nxt = sp_r + ((n1_r == 4'd0) ? 6'd2 : 6'd3);
        tok_nxt = '{mco_pkg::KIND_OPEN, 40'd0, 1'b0};
        state_nxt = S_WAIT; ret_nxt = S_POP;
      end
      S_WAIT: begin
        if (!obuf_v_r) begin
          obuf_v_nxt = 1'b1; obuf_nxt = tok_r; state_nxt = ret_r;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; obuf_v_r <= 1'b0; pipe_r <= '0;
      sp_r <= '0; first_r <= 1'b1;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; obuf_v_r <= obuf_v_nxt;
      pipe_r <= pipe_nxt; sp_r <= sp_nxt; first_r <= first_nxt;
    end
  end
  always_ff @(posedge clk) begin
    n1_r <= n1_nxt; len_r <= len_nxt; i_r <= i_nxt; t_r <= t_nxt;
    item_r <= item_nxt; obuf_r <= obuf_nxt; tok_r <= tok_nxt; ret_r <= ret_nxt;
  end

  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    dim_we |-> state_r == S_LOAD) else $error("dim write");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= 6'd32) else $error("stack");
endmodule
`default_nettype wire

[hw/rtl/matrix_chain_order_top.sv]
// Matrix-chain order top: controller plus datapath.
// Depends on mco_pkg, mco_ctrl, mco_datapath.
// Flow: dimensions load one per cycle; after the last, the controller fills the cost and
// split tables, then emits the cost token and the bracketed order.
// Throughput: one chain at a time; input stalled from last dimension until last token issues.
// Reset: synchronous active-low rst_n clears control; tables need no clearing.
`default_nettype none
module matrix_chain_order_top #(
  parameter int DIM_BITS  = 11,
  parameter int COST_BITS = 40
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mco_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mco_pkg::out_item_t     out_data
);
  logic dim_we, diag_we;
  logic [4:0] dim_waddr, dim_raddr_a;
  logic [3:0] ci, ct, cj, sp_rdata;
  logic [7:0] sp_raddr;
  logic [COST_BITS-1:0] cost_q;
  mco_pkg::dp_cmd_t cmd;

  mco_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid,
    .out_stall, .out_data, .dim_we, .dim_waddr, .dim_raddr_a, .ci, .ct, .cj, .cmd,
    .diag_we, .sp_raddr, .sp_rdata, .cost_q(40'(cost_q)));

  mco_datapath #(.DIM_BITS(DIM_BITS), .COST_BITS(COST_BITS)) u_dp (
    .clk, .dim_we, .dim_waddr, .dim_wdata(DIM_BITS'(in_data.dimension)),
    .dim_raddr_a, .ci, .ct, .cj, .cmd, .diag_we, .sp_raddr, .sp_rdata, .cost_q);
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for matrix_chain_order_top: dimension chains in, cost and bracketed order out.
// Depends on mco_pkg and the matrix_chain_order_top RTL; self-checking, no files read.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  mco_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  mco_pkg::out_item_t out_data;

  matrix_chain_order_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // chain predictor state
  logic [10:0]        chain_dims[17];
  int                 chain_len;
  logic [39:0]        span_cost[16][16];
  logic [3:0]         span_split[16][16];
  mco_pkg::out_item_t token_queue[$];

  int  mismatches;
  int  tokens_seen;
  int  items_sent;
  int  chains_sent;
  int  idle_cycles;
  int  hold_cycles;
  bit  rx_idle_en;
  bit  tx_idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic mco_pkg::out_item_t mk_token(mco_pkg::kind_t kind, logic [39:0] value);
    mco_pkg::out_item_t t;
    t.token_kind = kind;
    t.token_value = value;
    t.last_token = 1'b0;
    return t;
  endfunction

  task automatic predict_order(input int lo, input int hi);
    int s;
    if (lo == hi) begin
      token_queue.push_back(mk_token(mco_pkg::KIND_MAT, 40'(lo + 1)));
    end else begin
      s = span_split[lo][hi];
      token_queue.push_back(mk_token(mco_pkg::KIND_OPEN, 40'd0));
      predict_order(lo, s);
      predict_order(s + 1, hi);
      token_queue.push_back(mk_token(mco_pkg::KIND_CLOSE, 40'd0));
    end
  endtask

  task automatic predict_item(input mco_pkg::in_item_t item);
    int n;
    int span;
    int lo;
    int hi;
    int s;
    logic [39:0] c;
    logic [39:0] best;
    if (chain_len < 17) begin
      chain_dims[chain_len] = item.dimension;
      chain_len++;
    end
    if (!item.last_dimension) return;
    n = chain_len - 1;
    chain_len = 0;
    if (n == 0) begin
      token_queue.push_back(mk_token(mco_pkg::KIND_COST, 40'd0));
    end else begin
      for (lo = 0; lo < n; lo++) span_cost[lo][lo] = '0;
      for (span = 1; span < n; span++) begin
        for (lo = 0; lo + span < n; lo++) begin
          hi = lo + span;
          best = '0;
          for (s = lo; s < hi; s++) begin
            c = span_cost[lo][s] + span_cost[s + 1][hi] +
                40'(chain_dims[lo]) * 40'(chain_dims[s + 1]) * 40'(chain_dims[hi + 1]);
            if (s == lo || c < best) begin
              best = c;
              span_split[lo][hi] = 4'(s);
            end
          end
          span_cost[lo][hi] = best;
        end
      end
      token_queue.push_back(mk_token(mco_pkg::KIND_COST, span_cost[0][n - 1]));
      if (n == 1) begin
        token_queue.push_back(mk_token(mco_pkg::KIND_OPEN, 40'd0));
        predict_order(0, 0);
        token_queue.push_back(mk_token(mco_pkg::KIND_CLOSE, 40'd0));
      end else begin
        predict_order(0, n - 1);
      end
    end
    token_queue[$].last_token = 1'b1;
  endtask

  task automatic send_dim(input logic [10:0] dim, input bit last);
    mco_pkg::in_item_t item;
    item.dimension = dim;
    item.last_dimension = last;
    while (tx_idle_en && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(item);
    items_sent++;
    if (last) chains_sent++;
  endtask

  task automatic send_chain(input int n, input int max_dim);
    for (int k = 0; k <= n; k++)
      send_dim(11'($urandom_range(max_dim, 1)), k == n);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          if (out_data.token_kind !== token_queue[0].token_kind ||
              out_data.token_value !== token_queue[0].token_value ||
              out_data.last_token !== token_queue[0].last_token) begin
            $display("%0t: token mismatch, expected %h, actual %h",
                     $time, token_queue[0], out_data);
            mismatches++;
          end
          void'(token_queue.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= rx_idle_en && ($urandom_range(99) < 12);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic test_edge_chains();
    send_dim(11'd7, 1'b1);
    send_dim(11'd1, 1'b0); send_dim(11'd2000, 1'b1);
    send_dim(11'd2000, 1'b0); send_dim(11'd2000, 1'b0); send_dim(11'd2000, 1'b1);
    send_dim(11'd1, 1'b0); send_dim(11'd1, 1'b0); send_dim(11'd1, 1'b0);
    send_dim(11'd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_max_chain();
    for (int k = 0; k < 17; k++) send_dim(11'd2000, k == 16);
    wait_drained();
    for (int k = 0; k < 19; k++) send_dim(11'(k % 2 ? 11'h7ff : 11'd1 + k), k == 18);
    wait_drained();
  endtask

  task automatic test_random_chains();
    while (items_sent < 350) begin
      if ($urandom_range(9) == 0) send_chain($urandom_range(16), 2047);
      else send_chain($urandom_range(6), $urandom_range(1) ? 2047 : 20);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_cycles = 300;
    send_chain(3, 2047);
    send_chain(2, 2047);
    send_chain(1, 2047);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    tokens_seen = 0;
    items_sent = 0;
    chains_sent = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    chain_len = 0;
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_chains();
    test_max_chain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_chains();
    test_backpressure();
    repeat (50) @(posedge clk);
    $display("Sent %0d dimensions in %0d chains, checked %0d tokens,", items_sent,
             chains_sent, tokens_seen);
    $display("including overlong chains and a long output hold-off.");
    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
